// File: rtl/mlt_pkg.sv
// Shared types, constants and helper functions of the mini language tokenizer.
// Used by mlt_scan, mlt_outq and mini_language_tokenizer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mlt_pkg;

    // Default values for the top-level parameters.
    localparam int KEYWORD_MAX_LEN_DEF = 6;
    localparam int OFFSET_BITS_DEF     = 32;

    // Number of leading word characters that take part in the keyword compare.
    localparam int KW_CMP_LEN = 6;
    localparam int KW_COUNT   = 6;

    // Widths of the result channel.
    localparam int TDATA_W = 96;
    localparam int TUSER_W = 3;

    // Depth of the result queue, counted in input words.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_INTEGER = 3'd2,
        KIND_FLOAT   = 3'd3,
        KIND_OPER    = 3'd4,
        KIND_PUNCT   = 3'd5,
        KIND_UNKNOWN = 3'd6
    } kind_t;

    // Character codes the scanner tests against.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // Keyword text, first character in the lowest byte, in keyword id order:
    // int, float, if, else, while, return.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0074_6E69,
        48'h0074_616F_6C66,
        48'h0000_0000_6669,
        48'h0000_6573_6C65,
        48'h0065_6C69_6877,
        48'h6E72_7574_6572
    };
    localparam logic [47:0] KW_MASK [KW_COUNT] = '{
        48'h0000_00FF_FFFF,
        48'h00FF_FFFF_FFFF,
        48'h0000_0000_FFFF,
        48'h0000_FFFF_FFFF,
        48'h00FF_FFFF_FFFF,
        48'hFFFF_FFFF_FFFF
    };
    localparam logic [15:0] KW_LEN [KW_COUNT] = '{
        16'd3, 16'd5, 16'd2, 16'd4, 16'd5, 16'd6
    };

    typedef struct packed {
        logic       hit;
        logic [2:0] id;
    } kw_hit_t;

    // One token as it leaves the block.
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  kw_id;
        logic [31:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  single_char;
        logic        last;
    } res_t;

    // All tokens caused by one input word.
    typedef struct packed {
        res_t res0;
        res_t res1;
        logic two;
    } item_t;

    // Scanner status seen by the top level.
    typedef struct packed {
        logic idle;
    } scan_stat_t;

    // Result queue status seen by the top level.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    // Increment that sticks at the top of a 16-bit range.
    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Compares a word's leading characters and length against the keyword list.
    function automatic kw_hit_t kw_lookup(input logic [47:0] text, input logic [15:0] len);
        kw_hit_t r;
        r = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!r.hit && len == KW_LEN[i] && (text & KW_MASK[i]) == KW_TEXT[i]) begin
                r.hit = 1'b1;
                r.id  = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mlt_scan.sv
// Character scanner: word, number and position state, and token building.
// Depends on mlt_pkg; produces all tokens of one input word in the same cycle that the word is taken.
`timescale 1ns / 1ps
`default_nettype none

module mlt_scan #(
    parameter int KEYWORD_MAX_LEN = 6,
    parameter int OFFSET_BITS     = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              in_take,
    input  wire logic [7:0]        in_ch,
    input  wire logic              in_eot,
    output mlt_pkg::item_t         item_out,
    output logic                   item_push,
    output mlt_pkg::scan_stat_t    stat
);
    import mlt_pkg::*;

    localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);

    mode_t                  mode_reg, mode_next;
    logic                   point_reg, point_next;
    logic [7:0]             prefix_reg  [KEYWORD_MAX_LEN];
    logic [7:0]             prefix_next [KEYWORD_MAX_LEN];
    logic [15:0]            plen_reg, plen_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [15:0]            line_reg, line_next;
    logic [15:0]            col_reg, col_next;

    logic        is_letter, is_digit, is_point, is_space;
    logic        is_oper, is_punct;
    logic        taken, flush_old, single, start_word, start_num;
    mode_t       mode_mid;
    logic        flush_eot;
    logic [47:0] text_old, text_new;
    kw_hit_t     kw_old, kw_new;
    res_t        tok_old, tok_single, tok_eot;
    logic [OFFSET_BITS+31:0] off_ext, pstart_ext, pstart_next_ext;

    // Character classes.
    always_comb begin
        is_letter = (in_ch >= 8'h61 && in_ch <= 8'h7A) || (in_ch >= 8'h41 && in_ch <= 8'h5A);
        is_digit  = (in_ch >= 8'h30 && in_ch <= 8'h39);
        is_point  = (in_ch == CH_POINT);
        is_space  = (in_ch == CH_LF) || (in_ch == CH_SPACE) || (in_ch == CH_TAB)
                 || (in_ch == CH_CR);
        is_oper   = (in_ch == CH_PLUS) || (in_ch == CH_MINUS) || (in_ch == CH_STAR)
                 || (in_ch == CH_SLASH);
        is_punct  = (in_ch == CH_LPAREN) || (in_ch == CH_RPAREN) || (in_ch == CH_LBRACE)
                 || (in_ch == CH_RBRACE) || (in_ch == CH_SEMI);
    end

    // Decide whether the character extends, ends or starts a token.
    always_comb begin
        taken = ((mode_reg == MODE_WORD) && (is_letter || is_digit))
             || ((mode_reg == MODE_NUM) && (is_digit || (is_point && !point_reg)));
        flush_old  = (mode_reg != MODE_IDLE) && !taken;
        start_word = !taken && is_letter;
        start_num  = !taken && is_digit;
        single     = !taken && !is_space && !is_letter && !is_digit;
        mode_mid   = taken ? mode_reg : (start_word ? MODE_WORD :
                     (start_num ? MODE_NUM : MODE_IDLE));
        flush_eot  = in_eot && (mode_mid != MODE_IDLE);
    end

    // Next word prefix, pending length and start.
    always_comb begin
        for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
            prefix_next[i] = prefix_reg[i];
        end
        if (taken && mode_reg == MODE_WORD && plen_reg < 16'(KEYWORD_MAX_LEN)) begin
            prefix_next[plen_reg[IDX_W-1:0]] = in_ch;
        end
        if (start_word) begin
            prefix_next[0] = in_ch;
        end
        plen_next   = taken ? sat_inc16(plen_reg) :
                      ((start_word || start_num) ? 16'd1 : plen_reg);
        pstart_next = (start_word || start_num) ? off_reg : pstart_reg;
        point_next  = (taken && !flush_eot) ? (point_reg || (mode_reg == MODE_NUM && is_point))
                                             : 1'b0;
        mode_next   = flush_eot ? MODE_IDLE : mode_mid;
    end

    // Position counters.
    always_comb begin
        off_next  = (off_reg == {OFFSET_BITS{1'b1}}) ? off_reg
                                                     : off_reg + OFFSET_BITS'(1);
        line_next = (in_ch == CH_LF) ? sat_inc16(line_reg) : line_reg;
        col_next  = (in_ch == CH_LF) ? 16'd0 : sat_inc16(col_reg);
    end

    // Keyword lookups for the pending word before and after this character.
    always_comb begin
        for (int i = 0; i < KW_CMP_LEN; i++) begin
            text_old[8*i +: 8] = prefix_reg[i];
            text_new[8*i +: 8] = prefix_next[i];
        end
        kw_old = kw_lookup(text_old, plen_reg);
        kw_new = kw_lookup(text_new, plen_next);
    end

    // Build the three possible tokens.
    always_comb begin
        off_ext         = {32'd0, off_reg};
        pstart_ext      = {32'd0, pstart_reg};
        pstart_next_ext = {32'd0, pstart_next};

        tok_old             = '0;
        tok_old.kind        = (mode_reg == MODE_WORD) ? (kw_old.hit ? KIND_KEYWORD : KIND_IDENT)
                                                      : (point_reg ? KIND_FLOAT : KIND_INTEGER);
        tok_old.kw_id       = (mode_reg == MODE_WORD && kw_old.hit) ? kw_old.id : 3'd0;
        tok_old.start       = pstart_ext[31:0];
        tok_old.length      = plen_reg;
        tok_old.line        = line_reg;
        tok_old.column      = sat_inc16(col_reg);
        tok_old.single_char = 8'd0;

        tok_single             = '0;
        tok_single.kind        = is_oper ? KIND_OPER : (is_punct ? KIND_PUNCT : KIND_UNKNOWN);
        tok_single.kw_id       = 3'd0;
        tok_single.start       = off_ext[31:0];
        tok_single.length      = 16'd1;
        tok_single.line        = line_reg;
        tok_single.column      = sat_inc16(col_reg);
        tok_single.single_char = in_ch;

        tok_eot             = '0;
        tok_eot.kind        = (mode_mid == MODE_WORD) ? (kw_new.hit ? KIND_KEYWORD : KIND_IDENT)
                            : ((taken && (point_reg || is_point)) ? KIND_FLOAT : KIND_INTEGER);
        tok_eot.kw_id       = (mode_mid == MODE_WORD && kw_new.hit) ? kw_new.id : 3'd0;
        tok_eot.start       = pstart_next_ext[31:0];
        tok_eot.length      = plen_next;
        tok_eot.line        = line_next;
        tok_eot.column      = sat_inc16(col_next);
        tok_eot.single_char = 8'd0;
    end

    // Order the tokens of this word and mark the last one.
    always_comb begin
        item_out.two  = flush_old && (single || flush_eot);
        item_out.res0 = flush_old ? tok_old : (single ? tok_single : tok_eot);
        item_out.res1 = single ? tok_single : tok_eot;
        item_out.res0.last = !item_out.two;
        item_out.res1.last = 1'b1;
        item_push = in_take && (flush_old || single || flush_eot);
        stat.idle = (mode_reg == MODE_IDLE);
    end

    // Control and counter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            point_reg  <= 1'b0;
            plen_reg   <= 16'd0;
            pstart_reg <= '0;
            off_reg    <= '0;
            line_reg   <= 16'd1;
            col_reg    <= 16'd0;
        end else begin
            // A first_line write sets the line count only before any character is taken.
            if (cfg_we && !in_take && off_reg == '0) begin
                line_reg <= cfg_wdata;
            end
            if (in_take) begin
                mode_reg   <= mode_next;
                point_reg  <= point_next;
                plen_reg   <= plen_next;
                pstart_reg <= pstart_next;
                off_reg    <= off_next;
                line_reg   <= line_next;
                col_reg    <= col_next;
            end
        end
    end

    // Word prefix store; entries are only read once written within a word.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                prefix_reg[i] <= prefix_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mlt_outq.sv
// Result queue: holds the tokens of up to two input words and hands them out
// one token per transfer on the result channel. Depends on mlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlt_outq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  mlt_pkg::item_t                    push_item,
    output logic                              full,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output mlt_pkg::res_t                     out_res,
    output mlt_pkg::q_stat_t                  stat
);
    import mlt_pkg::*;

    item_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                sub_reg;
    item_t               head;
    logic                pop, adv;

    // Head entry and the token within it that is on offer.
    always_comb begin
        head      = entry_reg[rd_ptr_reg];
        out_valid = (count_reg != '0);
        out_res   = sub_reg ? head.res1 : head.res0;
        full      = (count_reg == QCNT_W'(QDEPTH));
        adv       = out_valid && out_ready;
        pop       = adv && (sub_reg || !head.two);
        stat.count = count_reg;
    end

    // Pointers, fill count and token index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
            end
            if (adv) begin
                sub_reg <= !pop;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mini_language_tokenizer.sv
// Mini language tokenizer, top level: scanner plus a two-word result queue.
// Each token is registered in the result queue before it is offered on m_.
// Takes one character per cycle while the result queue is not full; a character
// causing two tokens hands them out one per cycle while m_tready is high.
// Reset (aresetn low, synchronous) empties the queue, idles the scanner, clears
// offset and column, and sets the line count to 1.
`timescale 1ns / 1ps
`default_nettype none

module mini_language_tokenizer #(
    parameter int KEYWORD_MAX_LEN = mlt_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int OFFSET_BITS     = mlt_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // first_line register write
    input  wire logic                        cfg_we,
    input  wire logic [15:0]                 cfg_wdata,
    // character words
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,  // [7:0] ch
    input  wire logic                        s_tlast,  // end_of_text
    // token words
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [2:0] keyword_id, [34:3] token_start, [50:35] token_length, [66:51] line,
    // [82:67] column, [90:83] single_char, [95:91] zero
    output logic [mlt_pkg::TDATA_W-1:0]      m_tdata,
    output logic [mlt_pkg::TUSER_W-1:0]      m_tuser,  // [2:0] token_kind
    output logic                             m_tlast   // last_of_run
);
    import mlt_pkg::*;

    logic       take, push, full;
    item_t      item;
    res_t       res;
    scan_stat_t scan_stat;
    q_stat_t    q_stat;

    // Accept a character whenever the queue has room for its tokens.
    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    mlt_scan #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .OFFSET_BITS     (OFFSET_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_take   (take),
        .in_ch     (s_tdata),
        .in_eot    (s_tlast),
        .item_out  (item),
        .item_push (push),
        .stat      (scan_stat)
    );

    mlt_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (item),
        .full      (full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .stat      (q_stat)
    );

    // Pack the token onto the result channel.
    assign m_tdata = {5'd0, res.single_char, res.column, res.line, res.length,
                      res.start, res.kw_id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // An end-of-text character always leaves the scanner idle.
    a_eot_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_tlast) |=> scan_stat.idle)
        else $error("scanner not idle after end of text");

    // The queue never holds more words than it has entries.
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // Only keyword tokens carry a nonzero keyword id.
    a_kw_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_KEYWORD) |-> (m_tdata[2:0] == 3'd0))
        else $error("keyword id on a non-keyword token");

    // A valid token never has an unused kind code.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 3'd7))
        else $error("invalid token kind");

endmodule

`default_nettype wire
